/* hdl/assert_macros.svh */
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/bisect_pkg.sv */
// shared constants and types of the bisection triangle block
// no dependencies
package bisect_pkg;

	localparam int MAX_DEPTH_DEF   = 16;
	localparam int COORD_WIDTH_DEF = 24;
	localparam int INDEX_WIDTH     = 17;
	localparam int DEPTH_WIDTH     = 5;
	localparam int REG_IDX_WIDTH   = 3;
	localparam int NUM_COORDS      = 6;

	localparam int C_AX = 0;
	localparam int C_AY = 1;
	localparam int C_BX = 2;
	localparam int C_BY = 3;
	localparam int C_CX = 4;
	localparam int C_CY = 5;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_ROOT_A_X,
		REG_ROOT_A_Y,
		REG_ROOT_B_X,
		REG_ROOT_B_Y,
		REG_ROOT_C_X,
		REG_ROOT_C_Y,
		REG_VERTEX_ORDER
	} reg_index_t;

	typedef struct packed {
		logic advance;
		logic order;
	} cell_ctrl_t;

endpackage

/* hdl/bisect_cell.sv */
// one bisection level of the cell chain
// depends on bisect_pkg
module bisect_cell #(
	parameter int COORD_WIDTH = bisect_pkg::COORD_WIDTH_DEF,
	parameter int MAX_DEPTH   = bisect_pkg::MAX_DEPTH_DEF,
	parameter int CNT_W       = $clog2(MAX_DEPTH + 1)
) (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  bisect_pkg::cell_ctrl_t                            ctrl,
	input  logic                                              in_valid,
	input  logic [CNT_W-1:0]                                  in_rem,
	input  logic [MAX_DEPTH-1:0]                              in_path,
	input  logic [bisect_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] in_corners,
	output logic                                              out_valid,
	output logic [CNT_W-1:0]                                  out_rem,
	output logic [MAX_DEPTH-1:0]                              out_path,
	output logic [bisect_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] out_corners
);
	import bisect_pkg::*;

	function automatic logic [COORD_WIDTH-1:0] mid(input logic [COORD_WIDTH-1:0] p,
			input logic [COORD_WIDTH-1:0] q);
		logic [COORD_WIDTH:0] s;
		s = {p[COORD_WIDTH-1], p} + {q[COORD_WIDTH-1], q};
		return s[COORD_WIDTH:1];
	endfunction

	logic                                    active;
	logic                                    right;
	logic [COORD_WIDTH-1:0]                  mx;
	logic [COORD_WIDTH-1:0]                  my;
	logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] nxt;

	assign active = (in_rem != '0);
	assign right  = in_path[MAX_DEPTH-1];

	always_comb begin
		nxt = in_corners;
		if (!ctrl.order) begin
			mx = mid(in_corners[C_AX], in_corners[C_BX]);
			my = mid(in_corners[C_AY], in_corners[C_BY]);
		end else begin
			mx = mid(in_corners[C_AX], in_corners[C_CX]);
			my = mid(in_corners[C_AY], in_corners[C_CY]);
		end
		if (active) begin
			if (!ctrl.order) begin
				if (!right) begin
					nxt[C_AX] = in_corners[C_CX];
					nxt[C_AY] = in_corners[C_CY];
					nxt[C_BX] = in_corners[C_AX];
					nxt[C_BY] = in_corners[C_AY];
				end else begin
					nxt[C_AX] = in_corners[C_BX];
					nxt[C_AY] = in_corners[C_BY];
					nxt[C_BX] = in_corners[C_CX];
					nxt[C_BY] = in_corners[C_CY];
				end
				nxt[C_CX] = mx;
				nxt[C_CY] = my;
			end else begin
				if (!right) begin
					nxt[C_AX] = in_corners[C_AX];
					nxt[C_AY] = in_corners[C_AY];
					nxt[C_CX] = in_corners[C_BX];
					nxt[C_CY] = in_corners[C_BY];
				end else begin
					nxt[C_AX] = in_corners[C_BX];
					nxt[C_AY] = in_corners[C_BY];
					nxt[C_CX] = in_corners[C_CX];
					nxt[C_CY] = in_corners[C_CY];
				end
				nxt[C_BX] = mx;
				nxt[C_BY] = my;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ctrl.advance) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			out_rem     <= active ? in_rem - CNT_W'(1) : '0;
			out_path    <= {in_path[MAX_DEPTH-2:0], 1'b0};
			out_corners <= nxt;
		end
	end

endmodule

/* hdl/bisection_triangle_from_node.sv */
// top level of the bisection triangle block: configuration registers and cell chain
// depends on bisect_pkg, bisect_cell and assert_macros.svh
//
// A node (heap index, depth) enters a chain of MAX_DEPTH cells, one bisection level
// per cell, and its leaf triangle leaves the tail after the last cell. A new node
// is taken in every cycle while the result side keeps up; when a finished result
// waits at the output, the whole chain holds and in_ready drops. The configuration
// port is always ready; the user writes it while no node is in flight (unenforced).
`include "assert_macros.svh"

module bisection_triangle_from_node #(
	parameter int MAX_DEPTH   = bisect_pkg::MAX_DEPTH_DEF,
	parameter int COORD_WIDTH = bisect_pkg::COORD_WIDTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [bisect_pkg::REG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [COORD_WIDTH-1:0]                 cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [bisect_pkg::INDEX_WIDTH-1:0]     heap_index,
	input  logic [bisect_pkg::DEPTH_WIDTH-1:0]     node_depth,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [COORD_WIDTH-1:0]          corner_a_x,
	output logic signed [COORD_WIDTH-1:0]          corner_a_y,
	output logic signed [COORD_WIDTH-1:0]          corner_b_x,
	output logic signed [COORD_WIDTH-1:0]          corner_b_y,
	output logic signed [COORD_WIDTH-1:0]          corner_c_x,
	output logic signed [COORD_WIDTH-1:0]          corner_c_y
);
	import bisect_pkg::*;

	localparam int CNT_W = $clog2(MAX_DEPTH + 1);

	logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] root_q;
	logic                                    vertex_order_q;

	cell_ctrl_t                              ctrl;
	logic                                    stall;
	logic [DEPTH_WIDTH-1:0]                  depth_sat;
	logic [CNT_W-1:0]                        shamt;
	logic [MAX_DEPTH+INDEX_WIDTH-1:0]        idx_wide;
	logic [MAX_DEPTH-1:0]                    idx_ext;

	logic [MAX_DEPTH:0]                      v;
	logic [CNT_W-1:0]                        rem     [MAX_DEPTH+1];
	logic [MAX_DEPTH-1:0]                    path    [MAX_DEPTH+1];
	logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] corners [MAX_DEPTH+1];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q         <= '0;
			vertex_order_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_index_t'(cfg_index))
				REG_ROOT_A_X:     root_q[C_AX]   <= cfg_data;
				REG_ROOT_A_Y:     root_q[C_AY]   <= cfg_data;
				REG_ROOT_B_X:     root_q[C_BX]   <= cfg_data;
				REG_ROOT_B_Y:     root_q[C_BY]   <= cfg_data;
				REG_ROOT_C_X:     root_q[C_CX]   <= cfg_data;
				REG_ROOT_C_Y:     root_q[C_CY]   <= cfg_data;
				REG_VERTEX_ORDER: vertex_order_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign stall        = v[MAX_DEPTH] && !out_ready;
	assign ctrl.advance = !stall;
	assign ctrl.order   = vertex_order_q;
	assign in_ready     = !stall;

	// path bits aligned so the first step reads the top bit
	assign depth_sat = (node_depth > DEPTH_WIDTH'(MAX_DEPTH)) ? DEPTH_WIDTH'(MAX_DEPTH)
	                                                        : node_depth;
	assign shamt     = CNT_W'(MAX_DEPTH) - depth_sat[CNT_W-1:0];
	assign idx_wide  = {{MAX_DEPTH{1'b0}}, heap_index};
	assign idx_ext   = idx_wide[MAX_DEPTH-1:0];

	assign v[0]       = in_valid;
	assign rem[0]     = depth_sat[CNT_W-1:0];
	assign path[0]    = idx_ext << shamt;
	assign corners[0] = root_q;

	for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_cell
		bisect_cell #(
			.COORD_WIDTH (COORD_WIDTH),
			.MAX_DEPTH   (MAX_DEPTH),
			.CNT_W       (CNT_W)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.in_valid    (v[k]),
			.in_rem      (rem[k]),
			.in_path     (path[k]),
			.in_corners  (corners[k]),
			.out_valid   (v[k+1]),
			.out_rem     (rem[k+1]),
			.out_path    (path[k+1]),
			.out_corners (corners[k+1])
		);
	end

	assign out_valid  = v[MAX_DEPTH];
	assign corner_a_x = corners[MAX_DEPTH][C_AX];
	assign corner_a_y = corners[MAX_DEPTH][C_AY];
	assign corner_b_x = corners[MAX_DEPTH][C_BX];
	assign corner_b_y = corners[MAX_DEPTH][C_BY];
	assign corner_c_x = corners[MAX_DEPTH][C_CX];
	assign corner_c_y = corners[MAX_DEPTH][C_CY];

	`ASSERT_ALWAYS(a_tail_done, clk, arst_n, !v[MAX_DEPTH] || (rem[MAX_DEPTH] == '0), "result left with bisection steps pending")
	`ASSERT_NEXT(a_hold_chain, clk, arst_n, stall, $stable(v[MAX_DEPTH:1]), "cell chain moved while stalled")
	`ASSERT_NEXT(a_enter, clk, arst_n, in_valid && in_ready, v[1], "accepted node missing from first cell")

endmodule

/* tb/sv/tb.sv */
// testbench for bisection_triangle_from_node: directed table then randomized phases
// depends on bisect_pkg and the bisection_triangle_from_node rtl
// results are checked against a leaf-triangle predictor kept inside this file
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bisect_pkg::*;

	localparam int MAX_DEPTH = MAX_DEPTH_DEF;
	localparam int CW        = COORD_WIDTH_DEF;
	localparam int PHASES    = 8;
	localparam int PHASE_NODES = 128;
	localparam int LONG_HOLD = 200;

	localparam logic [REG_IDX_WIDTH-1:0] REG_PAST_END = REG_IDX_WIDTH'(REG_VERTEX_ORDER + 1);
	localparam logic [1:0] PACE_TX = 2'b01;
	localparam logic [1:0] PACE_RX = 2'b10;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [NUM_COORDS-1:0][CW-1:0] corners_t;

	localparam coord_t COORD_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam coord_t NEG_ONE   = '1;

	typedef struct packed {
		logic [INDEX_WIDTH-1:0] idx;
		logic [DEPTH_WIDTH-1:0] depth;
		corners_t               leaf;
	} leaf_expect_t;

	typedef struct packed {
		logic [1:0]             root_sel;
		logic                   order;
		logic [INDEX_WIDTH-1:0] idx;
		logic [DEPTH_WIDTH-1:0] depth;
		logic                   typed;
		corners_t               want;
	} node_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [REG_IDX_WIDTH-1:0] cfg_index;
	logic [CW-1:0]            cfg_data;
	logic                     in_valid;
	logic                     in_ready;
	logic [INDEX_WIDTH-1:0]   heap_index;
	logic [DEPTH_WIDTH-1:0]   node_depth;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [CW-1:0]     corner_a_x;
	logic signed [CW-1:0]     corner_a_y;
	logic signed [CW-1:0]     corner_b_x;
	logic signed [CW-1:0]     corner_b_y;
	logic signed [CW-1:0]     corner_c_x;
	logic signed [CW-1:0]     corner_c_y;

	corners_t     root_cfg;
	logic         order_cfg;
	leaf_expect_t leaf_q[$];
	node_row_t    directed[$];
	logic [1:0]   pace;
	logic         hold_armed;
	int           mismatches;
	int           nodes_sent;
	int           deep_nodes;
	int           leaves_checked;
	int           reg_writes;
	int           settings;
	string        coord_names[NUM_COORDS] = '{"a_x", "a_y", "b_x", "b_y", "c_x", "c_y"};

	bisection_triangle_from_node #(
		.MAX_DEPTH(MAX_DEPTH),
		.COORD_WIDTH(CW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.heap_index(heap_index),
		.node_depth(node_depth),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.corner_a_x(corner_a_x),
		.corner_a_y(corner_a_y),
		.corner_b_x(corner_b_x),
		.corner_b_y(corner_b_y),
		.corner_c_x(corner_c_x),
		.corner_c_y(corner_c_y)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("bisection_triangle_from_node verification failed");
		$finish;
	end

	function automatic corners_t make_corners(input coord_t ax, input coord_t ay,
			input coord_t bx, input coord_t by, input coord_t cx, input coord_t cy);
		corners_t t;
		t[C_AX] = ax;
		t[C_AY] = ay;
		t[C_BX] = bx;
		t[C_BY] = by;
		t[C_CX] = cx;
		t[C_CY] = cy;
		return t;
	endfunction

	function automatic corners_t root_set(input logic [1:0] sel);
		case (sel)
			2'd1: return make_corners(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
					COORD_MAX, COORD_MIN);
			2'd2: return make_corners(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
					COORD_MIN, COORD_MIN);
			2'd3: return make_corners(coord_t'(-3), coord_t'(5), coord_t'(1),
					coord_t'(-7), coord_t'(-1), coord_t'(2));
			default: return '0;
		endcase
	endfunction

	// floor of the half sum
	function automatic coord_t halfway(input coord_t p, input coord_t q);
		logic signed [CW:0] s;
		s = p + q;
		return s[CW:1];
	endfunction

	function automatic corners_t bisect_leaf(input logic [INDEX_WIDTH-1:0] idx,
			input logic [DEPTH_WIDTH-1:0] depth);
		coord_t ax, ay, bx, by, cx, cy, mx, my;
		int     lvl;
		ax = root_cfg[C_AX];
		ay = root_cfg[C_AY];
		bx = root_cfg[C_BX];
		by = root_cfg[C_BY];
		cx = root_cfg[C_CX];
		cy = root_cfg[C_CY];
		lvl = (depth > MAX_DEPTH) ? MAX_DEPTH - 1 : int'(depth) - 1;
		while (lvl >= 0) begin
			if (!order_cfg) begin
				mx = halfway(ax, bx);
				my = halfway(ay, by);
				if (idx[lvl])
					{ax, ay, bx, by} = {bx, by, cx, cy};
				else
					{ax, ay, bx, by} = {cx, cy, ax, ay};
				cx = mx;
				cy = my;
			end else begin
				mx = halfway(ax, cx);
				my = halfway(ay, cy);
				if (idx[lvl])
					{ax, ay} = {bx, by};
				else
					{cx, cy} = {bx, by};
				bx = mx;
				by = my;
			end
			lvl--;
		end
		return make_corners(ax, ay, bx, by, cx, cy);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch: %s", msg);
		mismatches++;
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [REG_IDX_WIDTH-1:0] idx, input logic [CW-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		reg_writes++;
		if (idx == REG_VERTEX_ORDER)
			order_cfg = data[0];
		else if (idx < REG_VERTEX_ORDER)
			root_cfg[idx] = data;
	endtask

	task automatic apply_config(input corners_t root, input logic order);
		logic [CW-1:0] junk;
		junk = CW'($urandom());
		write_reg(REG_ROOT_A_X, root[C_AX]);
		write_reg(REG_ROOT_A_Y, root[C_AY]);
		write_reg(REG_ROOT_B_X, root[C_BX]);
		write_reg(REG_ROOT_B_Y, root[C_BY]);
		write_reg(REG_ROOT_C_X, root[C_CX]);
		write_reg(REG_ROOT_C_Y, root[C_CY]);
		write_reg(REG_VERTEX_ORDER, {junk[CW-1:1], order});
		// an index past the register list must change nothing
		write_reg(REG_PAST_END, CW'($urandom()));
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// the caller's step is the acceptance edge of the last transaction
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (leaf_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_node(input logic [INDEX_WIDTH-1:0] idx,
			input logic [DEPTH_WIDTH-1:0] depth, input logic typed, input corners_t want);
		int           gap;
		leaf_expect_t e;
		gap = (pace & PACE_TX) ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		e.idx   = idx;
		e.depth = depth;
		e.leaf  = typed ? want : bisect_leaf(idx, depth);
		leaf_q.push_back(e);
		in_valid   <= 1'b1;
		heap_index <= idx;
		node_depth <= depth;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		nodes_sent++;
		if (depth > MAX_DEPTH)
			deep_nodes++;
	endtask

	task automatic check_leaf();
		corners_t     got;
		leaf_expect_t e;
		got = make_corners(corner_a_x, corner_a_y, corner_b_x, corner_b_y,
				corner_c_x, corner_c_y);
		leaves_checked++;
		if (leaf_q.size() == 0) begin
			report_mismatch($sformatf("leaf triangle with no node pending, a_x %0d",
					$signed(got[C_AX])));
			return;
		end
		e = leaf_q.pop_front();
		for (int k = 0; k < NUM_COORDS; k++) begin
			if (got[k] !== e.leaf[k])
				report_mismatch($sformatf("node %05h depth %0d %s got %0d want %0d",
						e.idx, e.depth, coord_names[k], $signed(got[k]),
						$signed(e.leaf[k])));
		end
	endtask

	task automatic add_row(input logic [1:0] sel, input logic order,
			input logic [INDEX_WIDTH-1:0] idx, input logic [DEPTH_WIDTH-1:0] depth,
			input logic typed, input corners_t want);
		node_row_t r;
		r.root_sel = sel;
		r.order    = order;
		r.idx      = idx;
		r.depth    = depth;
		r.typed    = typed;
		r.want     = want;
		directed.push_back(r);
	endtask

	// result side
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = (pace & PACE_RX) ? $urandom_range(0, 7) : 0;
			if (hold_armed) begin
				stall = LONG_HOLD;
				hold_armed = 1'b0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			check_leaf();
		end
	end

	initial begin
		node_row_t                row;
		corners_t                 root;
		logic [1:0]               cur_sel;
		logic                     cur_order;
		logic [DEPTH_WIDTH-1:0]   depth;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		heap_index = '0;
		node_depth = '0;
		root_cfg   = '0;
		order_cfg  = 1'b0;
		pace       = PACE_TX | PACE_RX;
		hold_armed = 1'b0;
		mismatches = 0;
		nodes_sent = 0;
		deep_nodes = 0;
		leaves_checked = 0;
		reg_writes = 0;
		settings   = 0;

		root = root_set(2'd1);
		add_row(2'd0, 1'b0, '0, 5'd0, 1'b1, '0);
		add_row(2'd0, 1'b0, '1, 5'd16, 1'b1, '0);
		add_row(2'd1, 1'b0, '0, 5'd0, 1'b1, root);
		add_row(2'd1, 1'b0, '1, 5'd0, 1'b1, root);
		add_row(2'd1, 1'b0, '0, 5'd1, 1'b1, make_corners(COORD_MAX, COORD_MIN,
				COORD_MAX, COORD_MAX, NEG_ONE, NEG_ONE));
		add_row(2'd1, 1'b0, 17'h00001, 5'd1, 1'b1, make_corners(COORD_MIN, COORD_MIN,
				COORD_MAX, COORD_MIN, NEG_ONE, NEG_ONE));
		add_row(2'd1, 1'b0, 17'h1FFFE, 5'd1, 1'b1, make_corners(COORD_MAX, COORD_MIN,
				COORD_MAX, COORD_MAX, NEG_ONE, NEG_ONE));
		add_row(2'd1, 1'b0, '0, 5'd16, 1'b0, '0);
		add_row(2'd1, 1'b0, '1, 5'd16, 1'b0, '0);
		add_row(2'd1, 1'b0, '1, 5'd31, 1'b0, '0);
		add_row(2'd1, 1'b0, 17'h0AAAA, 5'd17, 1'b0, '0);
		add_row(2'd1, 1'b0, 17'h15555, 5'd16, 1'b0, '0);
		add_row(2'd1, 1'b1, '0, 5'd0, 1'b1, root);
		add_row(2'd1, 1'b1, '0, 5'd1, 1'b1, make_corners(COORD_MAX, COORD_MAX,
				COORD_MAX, NEG_ONE, COORD_MIN, COORD_MIN));
		add_row(2'd1, 1'b1, 17'h00001, 5'd1, 1'b1, make_corners(COORD_MIN, COORD_MIN,
				COORD_MAX, NEG_ONE, COORD_MAX, COORD_MIN));
		add_row(2'd1, 1'b1, '1, 5'd16, 1'b0, '0);
		add_row(2'd1, 1'b1, '0, 5'd31, 1'b0, '0);
		add_row(2'd1, 1'b1, 17'h12345, 5'd9, 1'b0, '0);
		add_row(2'd3, 1'b0, 17'h00005, 5'd3, 1'b0, '0);
		add_row(2'd3, 1'b0, '1, 5'd16, 1'b0, '0);
		add_row(2'd3, 1'b1, 17'h0000A, 5'd4, 1'b0, '0);
		add_row(2'd3, 1'b1, '0, 5'd16, 1'b0, '0);
		add_row(2'd2, 1'b1, '1, 5'd31, 1'b0, '0);
		add_row(2'd2, 1'b0, 17'h10000, 5'd16, 1'b0, '0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// the first rows see the registers as reset left them
		cur_sel   = 2'd0;
		cur_order = 1'b0;
		settings  = 1;
		foreach (directed[r]) begin
			row = directed[r];
			if (row.root_sel != cur_sel || row.order != cur_order) begin
				settle();
				apply_config(root_set(row.root_sel), row.order);
				cur_sel   = row.root_sel;
				cur_order = row.order;
			end
			send_node(row.idx, row.depth, row.typed, row.want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			for (int k = 0; k < NUM_COORDS; k++) begin
				if (phase == 0)
					root[k] = COORD_MAX;
				else if (phase == 1)
					root[k] = COORD_MIN;
				else begin
					case ($urandom_range(0, 7))
						0: root[k] = COORD_MAX;
						1: root[k] = COORD_MIN;
						2: root[k] = coord_t'(int'($urandom_range(0, 16)) - 8);
						default: root[k] = coord_t'($urandom());
					endcase
				end
			end
			apply_config(root, phase[0]);
			pace = 2'(phase % 4);
			if (phase == 0 || phase == 5)
				hold_armed = 1'b1;
			repeat (PHASE_NODES) begin
				if ($urandom_range(0, 9) == 0)
					depth = DEPTH_WIDTH'($urandom_range(17, 31));
				else
					depth = DEPTH_WIDTH'($urandom_range(0, 16));
				send_node(INDEX_WIDTH'($urandom_range(0, 17'h1FFFF)), depth, 1'b0, '0);
			end
		end

		settle();
		repeat (4 * MAX_DEPTH) @(posedge clk);
		if (leaf_q.size() != 0)
			report_mismatch($sformatf("%0d leaf triangles never arrived", leaf_q.size()));

		$display("covered %0d nodes (%0d past the depth limit) under %0d register settings",
				nodes_sent, deep_nodes, settings);
		$display("%0d register writes, %0d leaf triangles checked, %0d mismatches",
				reg_writes, leaves_checked, mismatches);
		if (mismatches == 0)
			$display("bisection_triangle_from_node verification clean");
		else
			$display("bisection_triangle_from_node verification failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hdl
hdl/bisect_pkg.sv
hdl/bisect_cell.sv
hdl/bisection_triangle_from_node.sv
tb/sv/tb.sv
